// ===== sv/gpms_pkg.sv =====
// ----------------------------------------------------------------------------
// gpms_pkg
// Shared widths, register codes, reset values and window control types of the
// gated pitch median smoother.
// ----------------------------------------------------------------------------
package gpms_pkg;

    // Field widths
    localparam int FREQ_W  = 24;
    localparam int CONF_W  = 16;
    localparam int RMS_W   = 24;
    localparam int RATIO_W = 17;
    localparam int TOL_W   = 16;
    localparam int FRAC_W  = 16;                        // Q.16 scaling of ratio and tolerance
    localparam int PROD_W  = 1 + FREQ_W + FRAC_W;       // product and scaled compare width

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_CONF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACQ_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_RATIO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_TOL = 3'd4;

    // Register reset values
    localparam logic [CONF_W-1:0]  MIN_CONF_RST   = 16'd49152;
    localparam logic [RMS_W-1:0]   ACQ_LEVEL_RST  = 24'd13422;
    localparam logic [RMS_W-1:0]   TAIL_LEVEL_RST = 24'd2983;
    localparam logic [RATIO_W-1:0] TAIL_RATIO_RST = 17'd67456;
    localparam logic [TOL_W-1:0]   STABLE_TOL_RST = 16'd983;

    // Default sizing
    localparam int WINDOW_DEPTH_DEF = 5;
    localparam int STABLE_MIN_DEF   = 3;

    // Window control, top level to cell chain
    typedef struct packed {
        logic insert;        // write the new frequency into the window
        logic full;          // window full: shift out the oldest entry
        logic probe_load;    // copy entries into the probe line
        logic probe_shift;   // move probes one cell toward cell 0
    } t_win_ctrl;

endpackage

// ===== sv/gpms_cell.sv =====
// ----------------------------------------------------------------------------
// gpms_cell
// One window slot: holds an entry and a probe copy, ranks its entry against
// the broadcast candidate and checks its deviation from the median.
// ----------------------------------------------------------------------------
module gpms_cell #(
    parameter int J  = 0,
    parameter int CW = 3
) (
    input  logic                          i_clk,
    input  gpms_pkg::t_win_ctrl           i_ctrl,
    input  logic [CW-1:0]                 i_n,
    input  logic [CW-1:0]                 i_k,
    input  logic [gpms_pkg::FREQ_W-1:0]   i_new,
    input  logic [gpms_pkg::FREQ_W-1:0]   i_shift_in,
    input  logic [gpms_pkg::FREQ_W-1:0]   i_probe_in,
    input  logic [gpms_pkg::FREQ_W-1:0]   i_cand,
    input  logic [gpms_pkg::FREQ_W-1:0]   i_med,
    input  logic [gpms_pkg::PROD_W-1:0]   i_lim,
    output logic [gpms_pkg::FREQ_W-1:0]   o_value,
    output logic [gpms_pkg::FREQ_W-1:0]   o_probe,
    output logic                          o_lt,
    output logic                          o_ok
);
    import gpms_pkg::*;

    logic [FREQ_W-1:0] r_value;
    logic [FREQ_W-1:0] r_probe;
    logic              w_valid;
    logic [FREQ_W-1:0] w_dev;

    // Entry: age-ordered shift on a full window, else write at the fill point
    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert) begin
            if (i_ctrl.full) begin
                r_value <= i_shift_in;
            end else if (i_n == CW'(J)) begin
                r_value <= i_new;
            end
        end
    end

    // Probe line feeding candidates to cell 0
    always_ff @(posedge i_clk) begin
        if (i_ctrl.probe_load) begin
            r_probe <= r_value;
        end else if (i_ctrl.probe_shift) begin
            r_probe <= i_probe_in;
        end
    end

    assign w_valid = (i_n > CW'(J));

    // Sorts before candidate k: smaller, or equal and older
    assign o_lt = w_valid && ((r_value < i_cand) || ((r_value == i_cand) && (CW'(J) < i_k)));

    // Deviation check against median*tolerance
    assign w_dev = (r_value > i_med) ? (r_value - i_med) : (i_med - r_value);
    assign o_ok  = !w_valid || ({1'b0, w_dev, {FRAC_W{1'b0}}} < i_lim);

    assign o_value = r_value;
    assign o_probe = r_probe;

endmodule

// ===== sv/gpms_window.sv =====
// ----------------------------------------------------------------------------
// gpms_window
// Row of window cells with neighbor shift and probe lines; sums the rank of
// the current candidate and combines the per-cell stability checks.
// ----------------------------------------------------------------------------
module gpms_window #(
    parameter int DEPTH = 5,
    parameter int CW    = 3
) (
    input  logic                          i_clk,
    input  gpms_pkg::t_win_ctrl           i_ctrl,
    input  logic [CW-1:0]                 i_n,
    input  logic [CW-1:0]                 i_k,
    input  logic [gpms_pkg::FREQ_W-1:0]   i_new,
    input  logic [gpms_pkg::FREQ_W-1:0]   i_med,
    input  logic [gpms_pkg::PROD_W-1:0]   i_lim,
    output logic [gpms_pkg::FREQ_W-1:0]   o_cand,
    output logic [CW-1:0]                 o_rank,
    output logic                          o_all_ok
);
    import gpms_pkg::*;

    logic [FREQ_W-1:0] w_value [DEPTH];
    logic [FREQ_W-1:0] w_probe [DEPTH];
    logic [DEPTH-1:0]  w_lt;
    logic [DEPTH-1:0]  w_ok;

    assign o_cand = w_probe[0];

    // Cell chain
    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        logic [FREQ_W-1:0] w_shift_in;
        logic [FREQ_W-1:0] w_probe_in;

        if (j == DEPTH - 1) begin : g_last
            assign w_shift_in = i_new;
            assign w_probe_in = w_probe[j];
        end else begin : g_mid
            assign w_shift_in = w_value[j+1];
            assign w_probe_in = w_probe[j+1];
        end

        gpms_cell #(
            .J  (j),
            .CW (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (i_ctrl),
            .i_n        (i_n),
            .i_k        (i_k),
            .i_new      (i_new),
            .i_shift_in (w_shift_in),
            .i_probe_in (w_probe_in),
            .i_cand     (w_probe[0]),
            .i_med      (i_med),
            .i_lim      (i_lim),
            .o_value    (w_value[j]),
            .o_probe    (w_probe[j]),
            .o_lt       (w_lt[j]),
            .o_ok       (w_ok[j])
        );
    end

    // Rank of the candidate: count of entries sorting before it
    always_comb begin
        o_rank = '0;
        for (int j = 0; j < DEPTH; j++) begin
            o_rank = o_rank + CW'(w_lt[j]);
        end
    end

    assign o_all_ok = &w_ok;

endmodule

// ===== sv/gated_pitch_median_smoother.sv =====
// ----------------------------------------------------------------------------
// gated_pitch_median_smoother
// Gates pitch frames on presence, confidence and level, keeps an age-ordered
// window of accepted frequencies and gives its upper median and a stability
// flag.
// ----------------------------------------------------------------------------
//  channel   | direction | signals                      | request moves
//  ----------+-----------+------------------------------+--------------------------
//  s_axis    | in        | tvalid tready tdata tuser    | one pitch frame
//  m_axis    | out       | tvalid tready tdata tuser    | one result per frame
//  cfg       | in        | valid ready index data       | one register write
//
//  A frame gated out on presence, confidence or level goes straight to finish;
//  a frame accepted at normal level is inserted, then scanned and checked for
//  stability; a quiet frame is first scanned and ratio-tested before insertion.
//  The median scan walks one candidate per cycle down the probe line of the cell
//  row; one shared 24x17 multiplier serves the ratio and tolerance products.
//  Reset is synchronous, active low, and empties the window; no clearing pass.
//  A result waiting in the output register does not block the next frame until
//  that frame's own result is ready; cfg writes are taken in any cycle.
// ----------------------------------------------------------------------------
module gated_pitch_median_smoother #(
    parameter int WINDOW_DEPTH = gpms_pkg::WINDOW_DEPTH_DEF,
    parameter int STABLE_MIN   = gpms_pkg::STABLE_MIN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input frames
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [63:0]                       s_axis_tdata,  // frequency, confidence, rms
    input  logic [0:0]                        s_axis_tuser,  // freq_present
    // results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [63:0]                       m_axis_tdata,  // smoothed_frequency,
                                                             // confidence_echo, rms_echo
    output logic [1:0]                        m_axis_tuser,  // freq_valid, stable
    // register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gpms_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gpms_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gpms_pkg::*;

    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    // FSM codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_INS  = 4'd2;
    localparam logic [3:0] S_LOAD = 4'd3;
    localparam logic [3:0] S_SCAN = 4'd4;
    localparam logic [3:0] S_MULA = 4'd5;
    localparam logic [3:0] S_MULB = 4'd6;
    localparam logic [3:0] S_RCHK = 4'd7;
    localparam logic [3:0] S_MULC = 4'd8;
    localparam logic [3:0] S_STAB = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    // Configuration registers
    logic [CONF_W-1:0]  r_min_conf;
    logic [RMS_W-1:0]   r_acq_level;
    logic [RMS_W-1:0]   r_tail_level;
    logic [RATIO_W-1:0] r_tail_ratio;
    logic [TOL_W-1:0]   r_stable_tol;

    // Control state
    logic [3:0]    r_state;
    logic [CW-1:0] r_fill;
    logic [1:0]    r_run;
    logic          r_armed;
    logic          r_pre;
    logic [CW-1:0] r_k;
    logic          r_out_valid;

    // Payload
    logic              r_present;
    logic [FREQ_W-1:0] r_freq;
    logic [CONF_W-1:0] r_conf;
    logic [RMS_W-1:0]  r_rms;
    logic [FREQ_W-1:0] r_med;
    logic [PROD_W-1:0] r_mul;
    logic [PROD_W-1:0] r_hold;
    logic              r_res_ok;
    logic              r_res_stable;
    logic [63:0]       r_out_tdata;
    logic [1:0]        r_out_tuser;

    // Combinational
    logic              w_in_acc;
    logic              w_normal;
    logic              w_gate_ok;
    logic              w_quiet_ok;
    logic              w_full;
    logic              w_ratio_fail;
    logic              w_stable;
    logic              w_fin_go;
    logic              w_reject;
    logic [1:0]        n_run;
    logic [FREQ_W-1:0] w_mul_a;
    logic [RATIO_W-1:0] w_mul_b;
    t_win_ctrl         w_ctrl;
    logic [FREQ_W-1:0] w_cand;
    logic [CW-1:0]     w_rank;
    logic              w_all_ok;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

    // Gate decisions on the latched frame
    assign w_normal   = (r_rms >= r_acq_level);
    assign w_gate_ok  = r_present && (r_conf >= r_min_conf);
    assign w_quiet_ok = (r_rms >= r_tail_level) && r_armed && (r_fill != '0);
    assign w_full     = (r_fill == CW'(WINDOW_DEPTH));
    assign w_fin_go   = !r_out_valid || m_axis_tready;

    // Ratio test: r_hold = median*ratio, r_mul = freq*ratio
    assign w_ratio_fail = ({1'b0, r_freq, {FRAC_W{1'b0}}} > r_hold) ||
                          ({1'b0, r_med,  {FRAC_W{1'b0}}} > r_mul);

    assign w_stable = (32'(r_fill) >= STABLE_MIN) && w_all_ok;

    assign w_reject = ((r_state == S_CHK) && (!w_gate_ok || (!w_normal && !w_quiet_ok))) ||
                      ((r_state == S_RCHK) && w_ratio_fail);
    assign n_run    = (r_run == 2'd2) ? 2'd2 : (r_run + 2'd1);

    // Shared multiplier operands
    always_comb begin
        priority case (r_state)
            S_MULA:  begin w_mul_a = r_med;  w_mul_b = r_tail_ratio;        end
            S_MULB:  begin w_mul_a = r_freq; w_mul_b = r_tail_ratio;        end
            default: begin w_mul_a = r_med;  w_mul_b = {1'b0, r_stable_tol}; end
        endcase
    end

    // Window control
    always_comb begin
        w_ctrl.insert      = (r_state == S_INS);
        w_ctrl.full        = w_full;
        w_ctrl.probe_load  = (r_state == S_LOAD);
        w_ctrl.probe_shift = (r_state == S_SCAN);
    end

    gpms_window #(
        .DEPTH (WINDOW_DEPTH),
        .CW    (CW)
    ) u_window (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_n      (r_fill),
        .i_k      (r_k),
        .i_new    (r_freq),
        .i_med    (r_med),
        .i_lim    (r_mul),
        .o_cand   (w_cand),
        .o_rank   (w_rank),
        .o_all_ok (w_all_ok)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_conf   <= MIN_CONF_RST;
            r_acq_level  <= ACQ_LEVEL_RST;
            r_tail_level <= TAIL_LEVEL_RST;
            r_tail_ratio <= TAIL_RATIO_RST;
            r_stable_tol <= STABLE_TOL_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MIN_CONF:   r_min_conf   <= i_cfg_data[CONF_W-1:0];
                REG_ACQ_LEVEL:  r_acq_level  <= i_cfg_data[RMS_W-1:0];
                REG_TAIL_LEVEL: r_tail_level <= i_cfg_data[RMS_W-1:0];
                REG_TAIL_RATIO: r_tail_ratio <= i_cfg_data[RATIO_W-1:0];
                REG_STABLE_TOL: r_stable_tol <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_run       <= 2'd0;
            r_armed     <= 1'b0;
            r_pre       <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register: loaded on finish, else drained when taken
            if ((r_state == S_FIN) && w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // rejection bookkeeping
            if (w_reject) begin
                r_run <= n_run;
                if (n_run == 2'd2) begin
                    r_fill  <= '0;
                    r_armed <= 1'b0;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    priority if (!w_gate_ok) begin
                        r_state <= S_FIN;
                    end else if (w_normal) begin
                        r_state <= S_INS;
                    end else if (!w_quiet_ok) begin
                        r_state <= S_FIN;
                    end else begin
                        r_pre   <= 1'b1;
                        r_state <= S_LOAD;
                    end
                end
                S_INS: begin
                    r_run <= 2'd0;
                    r_pre <= 1'b0;
                    if (!w_full) begin
                        r_fill <= r_fill + CW'(1);
                    end
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_k     <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_k == r_fill - CW'(1)) begin
                        r_state <= r_pre ? S_MULA : S_MULC;
                    end else begin
                        r_k <= r_k + CW'(1);
                    end
                end
                S_MULA: r_state <= S_MULB;
                S_MULB: r_state <= S_RCHK;
                S_RCHK: r_state <= w_ratio_fail ? S_FIN : S_INS;
                S_MULC: r_state <= S_STAB;
                S_STAB: begin
                    if (w_normal && w_stable) begin
                        r_armed <= 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_fin_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_present <= s_axis_tuser[0];
            r_freq    <= s_axis_tdata[FREQ_W-1:0];
            r_conf    <= s_axis_tdata[FREQ_W +: CONF_W];
            r_rms     <= s_axis_tdata[FREQ_W+CONF_W +: RMS_W];
        end

        // median capture: candidate whose rank is n/2
        if ((r_state == S_SCAN) && (w_rank == (r_fill >> 1))) begin
            r_med <= w_cand;
        end

        // shared multiplier, one product per cycle
        if ((r_state == S_MULA) || (r_state == S_MULB) || (r_state == S_MULC)) begin
            r_mul <= PROD_W'(w_mul_a * w_mul_b);
        end
        if (r_state == S_MULB) begin
            r_hold <= r_mul;
        end

        // per-frame result
        if (r_state == S_CHK) begin
            r_res_ok     <= 1'b0;
            r_res_stable <= 1'b0;
        end else if (r_state == S_RCHK) begin
            r_res_ok     <= 1'b0;
            r_res_stable <= 1'b0;
        end else if (r_state == S_STAB) begin
            r_res_ok     <= 1'b1;
            r_res_stable <= w_stable;
        end

        // output register
        if ((r_state == S_FIN) && w_fin_go) begin
            r_out_tdata <= {r_rms, r_conf, (r_res_ok ? r_med : {FREQ_W{1'b0}})};
            r_out_tuser <= {r_res_stable, r_res_ok};
        end
    end

`ifndef SYNTHESIS
    // window never overfills
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(WINDOW_DEPTH))
        else $error("window fill above depth");

    // a saturated reject run leaves an empty, disarmed window
    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_run == 2'd2) |-> (r_fill == '0 && !r_armed))
        else $error("reject run saturated without clearing window");

    // scan candidate index stays inside the filled part
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k < r_fill))
        else $error("median scan beyond window fill");

    // stable only on an accepted result
    a_stable_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_tuser[1] && !r_out_tuser[0]))
        else $error("stable flag on rejected frame");

    // the check state is entered only after a frame was taken
    a_fin_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> $past(w_in_acc))
        else $error("check state entered without input request");
`endif

endmodule
